// ===== design/rclfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_pkg
// Shared constants, types and sequencer states of the RC link frame parser.
// ----------------------------------------------------------------------------
package rclfp_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int OFS_W           = 7;
  localparam int RAW_W           = 11;
  localparam int VAL_W           = 16;
  localparam int CNT_W           = 16;

  localparam logic [7:0]  ADDR_A        = 8'hC8;
  localparam logic [7:0]  ADDR_B        = 8'hEE;
  localparam logic [7:0]  TYPE_CHANNELS = 8'h16;
  localparam logic [7:0]  CRC_POLY      = 8'hD5;
  localparam logic [5:0]  LEN_MIN       = 6'd2;
  localparam logic [7:0]  LEN_MAX       = 8'd62;
  localparam logic [5:0]  CHAN_LEN      = 6'd24;
  localparam logic [6:0]  TYPE_OFS      = 7'd2;
  localparam logic [6:0]  PAYLOAD_OFS   = 7'd3;
  localparam logic [6:0]  PAYLOAD_END   = 7'd24;
  localparam logic [11:0] CHAN_MID      = 12'd992;
  localparam logic [10:0] CHAN_SPAN     = 11'd820;
  localparam logic [24:0] ROUND_HALF    = 25'd410;
  localparam logic [14:0] Q_ONE         = 15'd16384;
  localparam logic [16:0] THR_BIAS      = 17'd16385;
  localparam logic [4:0]  DIV_STEPS     = 5'd25;
  localparam logic [5:0]  MAX_RES       = 6'd32;
  localparam logic [7:0]  TIMEOUT_RST   = 8'd10;
  localparam logic [3:0]  CH_THR        = 4'd3;
  localparam logic [3:0]  CH_LAST       = 4'd15;

  localparam logic REG_MAP_TAER     = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_ADDR,
    ST_LEN,
    ST_CLOAD,
    ST_CBIT,
    ST_CCMP,
    ST_ULOAD,
    ST_UBIT,
    ST_ESEL,
    ST_EDIV,
    ST_EOUT
  } state_t;

  typedef struct packed {
    logic             start;
    logic             thr;
    logic [RAW_W-1:0] raw;
  } norm_req_t;

endpackage

// ===== design/rclfp_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rclfp_norm
// Bit-serial channel normalizer: (raw - 992) / 820 rounded, clamped, Q1.14; thr gives (value + 16385) / 2.
// ----------------------------------------------------------------------------
module rclfp_norm (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rclfp_pkg::norm_req_t          req,
  output logic                          done,
  output logic [rclfp_pkg::VAL_W-1:0]   value
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [24:0] q_r;
  logic [9:0]  rem_r;
  logic        neg_r, thr_r;

  logic [11:0] v;
  logic [10:0] mag;
  logic [24:0] dividend;
  logic [10:0] rem2;
  logic        ge;
  logic [14:0] clamp;
  logic [15:0] mag16, sval;
  logic [16:0] t17;

  assign v        = {1'b0, req.raw} - rclfp_pkg::CHAN_MID;
  assign mag      = v[11] ? 11'(12'd0 - v) : v[10:0];
  assign dividend = {mag, 14'd0} + rclfp_pkg::ROUND_HALF;
  assign rem2     = {rem_r, q_r[24]};
  assign ge       = rem2 >= rclfp_pkg::CHAN_SPAN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= rclfp_pkg::DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= dividend;
      rem_r <= '0;
      neg_r <= v[11];
      thr_r <= req.thr;
    end else if (busy_r) begin
      q_r   <= {q_r[23:0], ge};
      rem_r <= ge ? 10'(rem2 - rclfp_pkg::CHAN_SPAN) : rem2[9:0];
    end
  end

  assign clamp = (q_r[24:15] != '0 || q_r[14:0] > rclfp_pkg::Q_ONE) ?
                 rclfp_pkg::Q_ONE : q_r[14:0];
  assign mag16 = {1'b0, clamp};
  assign sval  = neg_r ? 16'd0 - mag16 : mag16;
  assign t17   = {sval[15], sval} + rclfp_pkg::THR_BIAS;
  assign value = thr_r ? t17[16:1] : sval;
  assign done  = done_r;

endmodule

// ===== design/rc_link_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser
// Receiver-link frame parser: buffers bytes, checks CRC8, emits RC channels.
// ----------------------------------------------------------------------------
// A tick item is taken in the idle state. A byte item is stored, then the
// block scans the buffer before taking the next item: a header check, a
// bit-serial CRC over length - 1 bytes, an unpack of the 176 channel bits,
// and a bit-serial divide per channel result, plus any wait on out_tready.
// A CRC failure rescans from the next byte, so a byte can cost up to the
// buffer fill times one frame check.
module rc_link_frame_parser #(
  parameter int STORE_DEPTH = rclfp_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [3:0] channel_index, [19:4] control_value,
                                  // [35:20] crc_error_total,
                                  // [51:36] stream_reset_total, zero fill
  output logic        out_tlast,  // last_channel
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int PTR_W  = $clog2(STORE_DEPTH);
  localparam int FILL_W = $clog2(STORE_DEPTH + 1);
  localparam int OFF_W  = (FILL_W > rclfp_pkg::OFS_W) ? FILL_W : rclfp_pkg::OFS_W;
  localparam int SUM_W  = OFF_W + 1;

  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                input logic [OFF_W-1:0] ofs);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(ofs);
    if (s >= SUM_W'(STORE_DEPTH)) s = s - SUM_W'(STORE_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  logic [7:0] mem [STORE_DEPTH];

  rclfp_pkg::state_t state_r, state_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        silence_r, silence_nxt;
  logic [15:0]       crc_err_r, crc_err_nxt;
  logic [15:0]       srst_r, srst_nxt;
  logic              taer_r;
  logic [7:0]        timeout_r;
  logic [5:0]        res_cnt_r, res_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [6:0]  off_r, off_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [15:0] val_r, val_nxt;
  logic        ushift;
  logic        oload;

  logic [rclfp_pkg::RAW_W-1:0] raw_r [16];

  logic [7:0]       rd_data_r;
  logic [PTR_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [FILL_W-1:0] fill_eff;
  logic             tmo;
  logic [SUM_W-1:0] total;
  logic [7:0]       crc_step;
  logic [3:0]       src;
  rclfp_pkg::norm_req_t req;
  logic             norm_done;
  logic [15:0]      norm_val;
  logic [55:0]      out_data_r;
  logic             out_last_r;

  assign in_tready = (state_r == rclfp_pkg::ST_IDLE);
  assign tmo       = (fill_r != '0) && (silence_r > timeout_r);
  assign fill_eff  = (tmo || fill_r == FILL_W'(STORE_DEPTH)) ? '0 : fill_r;
  assign wr_addr   = wrap_add(head_r, OFF_W'(fill_eff));
  assign rd_addr   = wrap_add(head_r, OFF_W'(off_nxt));
  assign total     = SUM_W'(len_r) + SUM_W'(2);
  assign crc_step  = crc_r[7] ? ((crc_r << 1) ^ rclfp_pkg::CRC_POLY) : (crc_r << 1);

  always_comb begin
    unique case (k_r)
      4'd0:    src = taer_r ? 4'd1 : 4'd0;
      4'd1:    src = taer_r ? 4'd2 : 4'd1;
      4'd2:    src = 4'd3;
      4'd3:    src = taer_r ? 4'd0 : 4'd2;
      default: src = k_r;
    endcase
  end

  assign req.start = (state_r == rclfp_pkg::ST_ESEL);
  assign req.thr   = (k_r == rclfp_pkg::CH_THR);
  assign req.raw   = raw_r[src];

  rclfp_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (norm_done),
    .value (norm_val)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    silence_nxt   = silence_r;
    crc_err_nxt   = crc_err_r;
    srst_nxt      = srst_r;
    res_cnt_nxt   = res_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    off_nxt       = off_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    type_nxt      = type_r;
    crc_nxt       = crc_r;
    sh_nxt        = sh_r;
    k_nxt         = k_r;
    val_nxt       = val_r;
    wr_en         = 1'b0;
    ushift        = 1'b0;
    oload         = 1'b0;
    unique case (state_r)
      rclfp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser[0]) begin
            if (silence_r != 8'hFF) silence_nxt = silence_r + 8'd1;
          end else begin
            if (tmo && srst_r != 16'hFFFF) srst_nxt = srst_r + 16'd1;
            silence_nxt = '0;
            wr_en       = 1'b1;
            fill_nxt    = fill_eff + FILL_W'(1);
            res_cnt_nxt = '0;
            state_nxt   = rclfp_pkg::ST_CHK;
          end
        end
      end
      rclfp_pkg::ST_CHK: begin
        if (fill_r < FILL_W'(3)) begin
          state_nxt = rclfp_pkg::ST_IDLE;
        end else begin
          off_nxt   = '0;
          state_nxt = rclfp_pkg::ST_ADDR;
        end
      end
      rclfp_pkg::ST_ADDR: begin
        if (rd_data_r != rclfp_pkg::ADDR_A && rd_data_r != rclfp_pkg::ADDR_B) begin
          head_nxt  = wrap_add(head_r, OFF_W'(1));
          fill_nxt  = fill_r - FILL_W'(1);
          state_nxt = rclfp_pkg::ST_CHK;
        end else begin
          off_nxt   = 7'd1;
          state_nxt = rclfp_pkg::ST_LEN;
        end
      end
      rclfp_pkg::ST_LEN: begin
        if (rd_data_r < 8'(rclfp_pkg::LEN_MIN) || rd_data_r > rclfp_pkg::LEN_MAX) begin
          head_nxt  = wrap_add(head_r, OFF_W'(1));
          fill_nxt  = fill_r - FILL_W'(1);
          state_nxt = rclfp_pkg::ST_CHK;
        end else if (SUM_W'(fill_r) < SUM_W'(rd_data_r) + SUM_W'(2)) begin
          state_nxt = rclfp_pkg::ST_IDLE;
        end else begin
          len_nxt   = rd_data_r[5:0];
          cnt_nxt   = rd_data_r[5:0] - 6'd1;
          crc_nxt   = '0;
          off_nxt   = rclfp_pkg::TYPE_OFS;
          state_nxt = rclfp_pkg::ST_CLOAD;
        end
      end
      rclfp_pkg::ST_CLOAD: begin
        if (off_r == rclfp_pkg::TYPE_OFS) type_nxt = rd_data_r;
        crc_nxt   = crc_r ^ rd_data_r;
        bit_nxt   = '0;
        state_nxt = rclfp_pkg::ST_CBIT;
      end
      rclfp_pkg::ST_CBIT: begin
        crc_nxt = crc_step;
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          cnt_nxt = cnt_r - 6'd1;
          if (cnt_r == 6'd1) begin
            off_nxt   = 7'(len_r) + 7'd1;
            state_nxt = rclfp_pkg::ST_CCMP;
          end else begin
            off_nxt   = off_r + 7'd1;
            state_nxt = rclfp_pkg::ST_CLOAD;
          end
        end
      end
      rclfp_pkg::ST_CCMP: begin
        if (crc_r != rd_data_r) begin
          if (crc_err_r != 16'hFFFF) crc_err_nxt = crc_err_r + 16'd1;
          head_nxt  = wrap_add(head_r, OFF_W'(1));
          fill_nxt  = fill_r - FILL_W'(1);
          state_nxt = rclfp_pkg::ST_CHK;
        end else if (type_r == rclfp_pkg::TYPE_CHANNELS && len_r == rclfp_pkg::CHAN_LEN
                     && res_cnt_r != rclfp_pkg::MAX_RES) begin
          off_nxt   = rclfp_pkg::PAYLOAD_OFS;
          state_nxt = rclfp_pkg::ST_ULOAD;
        end else begin
          head_nxt  = wrap_add(head_r, OFF_W'(total));
          fill_nxt  = fill_r - FILL_W'(total);
          state_nxt = rclfp_pkg::ST_CHK;
        end
      end
      rclfp_pkg::ST_ULOAD: begin
        sh_nxt    = rd_data_r;
        bit_nxt   = '0;
        state_nxt = rclfp_pkg::ST_UBIT;
      end
      rclfp_pkg::ST_UBIT: begin
        ushift  = 1'b1;
        sh_nxt  = sh_r >> 1;
        bit_nxt = bit_r + 3'd1;
        if (bit_r == 3'd7) begin
          if (off_r == rclfp_pkg::PAYLOAD_END) begin
            k_nxt     = '0;
            state_nxt = rclfp_pkg::ST_ESEL;
          end else begin
            off_nxt   = off_r + 7'd1;
            state_nxt = rclfp_pkg::ST_ULOAD;
          end
        end
      end
      rclfp_pkg::ST_ESEL: begin
        state_nxt = rclfp_pkg::ST_EDIV;
      end
      rclfp_pkg::ST_EDIV: begin
        if (norm_done) begin
          val_nxt   = norm_val;
          state_nxt = rclfp_pkg::ST_EOUT;
        end
      end
      rclfp_pkg::ST_EOUT: begin
        if (!out_valid_r || out_tready) begin
          oload         = 1'b1;
          out_valid_nxt = 1'b1;
          res_cnt_nxt   = res_cnt_r + 6'd1;
          k_nxt         = k_r + 4'd1;
          if (k_r == rclfp_pkg::CH_LAST) begin
            head_nxt  = wrap_add(head_r, OFF_W'(total));
            fill_nxt  = fill_r - FILL_W'(total);
            state_nxt = rclfp_pkg::ST_CHK;
          end else begin
            state_nxt = rclfp_pkg::ST_ESEL;
          end
        end
      end
      default: state_nxt = rclfp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rclfp_pkg::ST_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      silence_r   <= '0;
      crc_err_r   <= '0;
      srst_r      <= '0;
      res_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      taer_r      <= 1'b0;
      timeout_r   <= rclfp_pkg::TIMEOUT_RST;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      silence_r   <= silence_nxt;
      crc_err_r   <= crc_err_nxt;
      srst_r      <= srst_nxt;
      res_cnt_r   <= res_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index[0])
          rclfp_pkg::REG_MAP_TAER:     taer_r    <= cfg_wdata[0];
          rclfp_pkg::REG_IDLE_TIMEOUT: timeout_r <= cfg_wdata;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    bit_r  <= bit_nxt;
    cnt_r  <= cnt_nxt;
    len_r  <= len_nxt;
    type_r <= type_nxt;
    crc_r  <= crc_nxt;
    sh_r   <= sh_nxt;
    k_r    <= k_nxt;
    val_r  <= val_nxt;
    if (ushift) begin
      raw_r[15] <= {sh_r[0], raw_r[15][10:1]};
      for (int i = 0; i < 15; i++) raw_r[i] <= {raw_r[i+1][0], raw_r[i][10:1]};
    end
    if (oload) begin
      out_data_r <= {4'd0, srst_r, crc_err_r, val_r, k_r};
      out_last_r <= (k_r == rclfp_pkg::CH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_tdata;
    rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_byte_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> state_r == rclfp_pkg::ST_CHK)
    else $error("byte item did not start a scan");

  a_crc_err_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(crc_err_r) |-> crc_err_r == $past(crc_err_r) + 16'd1)
    else $error("crc error count moved by more than one");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rclfp_pkg::ST_CHK |-> fill_r <= FILL_W'(STORE_DEPTH))
    else $error("buffer fill beyond store depth");

endmodule

// ===== tb/rc_link_frame_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_link_frame_parser_test
// Streams link bytes and millisecond ticks into the frame parser and checks
// every channel result against a cycle-free predictor of the scan: CRC8
// checks, rescans, timeouts, full-buffer resyncs and the channel remap.
// Register settings change between phases while the parser is idle.
// ----------------------------------------------------------------------------
module rc_link_frame_parser_test;

  typedef struct {
    bit       tick;
    bit [7:0] data;
  } link_item_t;

  typedef struct {
    bit [3:0]  chan;
    bit [15:0] value;
    bit        last;
    bit [15:0] crc_errs;
    bit [15:0] resets;
  } chan_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  rc_link_frame_parser u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  link_item_t pend_q[$];
  chan_res_t  chan_exp_q[$];
  int         fails;
  int         items_made;

  // predictor state
  bit [7:0]  buf_b[64];
  int        buf_fill;
  int        quiet_ms;
  int        crc_errs;
  int        resets;
  bit        taer;
  int        tmo_ms;

  bit in_took, out_took, hold_req;
  int in_gap, out_gap, hold_cnt;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
  endfunction

  function automatic bit [7:0] crc8(bit [7:0] b[$]);
    bit [7:0] c;
    c = 0;
    foreach (b[i]) begin
      c ^= b[i];
      for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ rclfp_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic int norm_q14(int raw);
    int v, mag, q;
    v = raw - 992;
    mag = v < 0 ? -v : v;
    q = (mag * 16384 + 410) / 820;
    if (q > 16384) q = 16384;
    return v < 0 ? -q : q;
  endfunction

  function automatic void drop_front(int n);
    if (n >= buf_fill) begin
      buf_fill = 0;
      return;
    end
    for (int i = 0; i < buf_fill - n; i++) buf_b[i] = buf_b[i + n];
    buf_fill -= n;
  endfunction

  function automatic void emit_channels(ref int count);
    int raw[16], ctl[16];
    int acc, bits, bi;
    chan_res_t r;
    acc = 0; bits = 0; bi = 3;
    for (int ch = 0; ch < 16; ch++) begin
      while (bits < 11) begin
        acc |= int'(buf_b[bi]) << bits;
        bi++;
        bits += 8;
      end
      raw[ch] = norm_q14(acc & 'h7FF);
      acc >>= 11;
      bits -= 11;
    end
    ctl = raw;
    ctl[0] = raw[taer ? 1 : 0];
    ctl[1] = raw[taer ? 2 : 1];
    ctl[2] = raw[3];
    ctl[3] = (raw[taer ? 0 : 2] + 16385) >>> 1;
    if (ctl[3] < 0) ctl[3] = 0;
    if (ctl[3] > 16384) ctl[3] = 16384;
    for (int ch = 0; ch < 16 && count < 32; ch++, count++) begin
      r.chan = 4'(ch);
      r.value = 16'(ctl[ch]);
      r.last = (ch == 15);
      r.crc_errs = 16'(crc_errs);
      r.resets = 16'(resets);
      chan_exp_q.push_back(r);
    end
  endfunction

  function automatic void predict_item(link_item_t it);
    int count, len, total;
    bit [7:0] body[$];
    count = 0;
    if (it.tick) begin
      if (quiet_ms < 255) quiet_ms++;
      return;
    end
    if (buf_fill != 0 && quiet_ms > tmo_ms) begin
      buf_fill = 0;
      if (resets < 65535) resets++;
    end
    quiet_ms = 0;
    if (buf_fill >= 64) buf_fill = 0;
    buf_b[buf_fill] = it.data;
    buf_fill++;
    while (buf_fill >= 3) begin
      len = buf_b[1];
      if (buf_b[0] != rclfp_pkg::ADDR_A && buf_b[0] != rclfp_pkg::ADDR_B) begin
        drop_front(1);
        continue;
      end
      if (len < 2 || len > 62) begin drop_front(1); continue; end
      total = len + 2;
      if (buf_fill < total) break;
      body.delete();
      for (int i = 2; i < total - 1; i++) body.push_back(buf_b[i]);
      if (crc8(body) != buf_b[total - 1]) begin
        if (crc_errs < 65535) crc_errs++;
        drop_front(1);
        continue;
      end
      if (buf_b[2] == rclfp_pkg::TYPE_CHANNELS && len == 24) emit_channels(count);
      drop_front(total);
    end
  endfunction

  task automatic add_item(bit tick, bit [7:0] data);
    link_item_t it;
    it.tick = tick;
    it.data = data;
    pend_q.push_back(it);
    items_made++;
  endtask

  // kind: 0 channels, 1 other type, 2 bad crc channels
  task automatic add_frame(int kind, bit [7:0] addr, int raws[16]);
    bit [7:0] body[$];
    bit [175:0] packed_bits;
    int len;
    bit [7:0] c;
    if (kind == 1) begin
      len = $urandom_range(2, 40);
      body.push_back(8'($urandom_range(0, 255)));
      if (body[0] == rclfp_pkg::TYPE_CHANNELS) body[0] = 8'h14;
      for (int i = 0; i < len - 2; i++) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = 24;
      body.push_back(rclfp_pkg::TYPE_CHANNELS);
      for (int ch = 0; ch < 16; ch++) packed_bits[ch*11 +: 11] = 11'(raws[ch]);
      for (int i = 0; i < 22; i++) body.push_back(packed_bits[i*8 +: 8]);
    end
    c = crc8(body);
    if (kind == 2) c ^= 8'h01 << $urandom_range(0, 7);
    add_item(1'b0, addr);
    add_item(1'b0, 8'(len));
    foreach (body[i]) add_item(1'b0, body[i]);
    add_item(1'b0, c);
  endtask

  task automatic add_rand_frame(bit wide);
    int raws[16];
    bit [7:0] addr;
    int k;
    foreach (raws[i]) raws[i] = wide ? $urandom_range(0, 2047) : $urandom_range(172, 1811);
    addr = $urandom_range(0, 1) ? rclfp_pkg::ADDR_A : rclfp_pkg::ADDR_B;
    k = $urandom_range(0, 9);
    add_frame(k < 7 ? 0 : (k < 9 ? 1 : 2), addr, raws);
  endtask

  task automatic write_reg(bit [0:0] idx, bit [7:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == rclfp_pkg::REG_MAP_TAER) taer = val[0];
    else tmo_ms = val;
  endtask

  task automatic settle();
    wait (pend_q.size() == 0 && !in_tvalid && chan_exp_q.size() == 0);
    repeat (40000) @(posedge clk);
  endtask

  task automatic random_phase(int n_items);
    int k;
    int stop_at;
    stop_at = items_made + n_items;
    while (items_made < stop_at) begin
      k = $urandom_range(0, 19);
      if (k < 13) add_rand_frame(k == 0);
      else if (k < 15) repeat ($urandom_range(1, 6)) add_item(1'b0, 8'($urandom_range(0, 255)));
      else if (k < 17) repeat ($urandom_range(1, 3)) add_item(1'b1, 8'($urandom_range(0, 255)));
      else if (k < 18) begin
        add_item(1'b0, rclfp_pkg::ADDR_A);
        add_item(1'b0, 8'd24);
        repeat ($urandom_range(1, 10)) add_item(1'b0, 8'($urandom_range(0, 255)));
        repeat ((tmo_ms < 20) ? tmo_ms + $urandom_range(1, 2) : $urandom_range(1, 3))
          add_item(1'b1, 8'd0);
      end else if (k < 19) begin
        add_item(1'b0, rclfp_pkg::ADDR_B);
        add_item(1'b0, $urandom_range(0, 1) ? 8'd1 : 8'($urandom_range(63, 255)));
      end else begin
        add_item(1'b0, rclfp_pkg::ADDR_A);
        add_item(1'b0, 8'($urandom_range(2, 24)));
      end
    end
  endtask

  // input driver
  always @(negedge clk) begin
    link_item_t it;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_gap = 0;
    end else if (!(in_tvalid && !in_took)) begin
      if (in_took) begin
        in_took = 0;
        in_gap = draw_gap();
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 0;
      end else if (pend_q.size() != 0) begin
        it = pend_q.pop_front();
        in_tvalid <= 1;
        in_tdata <= it.data;
        in_tuser <= it.tick;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 3000;
      end
      if (out_took) begin
        out_took = 0;
        out_gap = draw_gap();
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // acceptance and checking
  always @(posedge clk) begin
    link_item_t it;
    chan_res_t e;
    if (rst_n && in_tvalid && in_tready) begin
      it.tick = in_tuser[0];
      it.data = in_tdata;
      predict_item(it);
      in_took = 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      out_took = 1;
      if (chan_exp_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result: tdata=%h tlast=%b", out_tdata, out_tlast);
      end else begin
        e = chan_exp_q.pop_front();
        if (out_tdata[3:0] !== e.chan || out_tdata[19:4] !== e.value ||
            out_tdata[35:20] !== e.crc_errs || out_tdata[51:36] !== e.resets ||
            out_tdata[55:52] !== 4'd0 || out_tlast !== e.last) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: exp ch=%0d val=%h last=%b crc=%0d rst=%0d got tdata=%h tlast=%b",
                     e.chan, e.value, e.last, e.crc_errs, e.resets, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    #300_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int raws[16];
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = 0;
    out_tready = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    fails = 0;
    items_made = 0;
    in_took = 0;
    out_took = 0;
    hold_req = 0;
    hold_cnt = 0;
    out_gap = 0;
    buf_fill = 0;
    quiet_ms = 0;
    crc_errs = 0;
    resets = 0;
    taer = 0;
    tmo_ms = 10;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // extremes of the raw range, midpoint and stick ends
    foreach (raws[i]) raws[i] = (i % 2) ? 2047 : 0;
    add_frame(0, rclfp_pkg::ADDR_A, raws);
    foreach (raws[i]) raws[i] = (i % 3 == 0) ? 992 : (i % 3 == 1 ? 172 : 1811);
    add_frame(0, rclfp_pkg::ADDR_B, raws);
    add_frame(1, rclfp_pkg::ADDR_A, raws);
    add_frame(2, rclfp_pkg::ADDR_B, raws);
    add_item(1'b0, 8'h00);
    add_item(1'b0, rclfp_pkg::ADDR_A);
    add_item(1'b0, 8'd1);
    add_item(1'b0, rclfp_pkg::ADDR_A);
    add_item(1'b0, 8'd63);
    add_item(1'b0, rclfp_pkg::ADDR_A);
    add_item(1'b0, 8'd24);
    repeat (11) add_item(1'b1, 8'hFF);
    add_item(1'b0, 8'h55);
    repeat (8) add_item(1'b0, 8'hAA);
    settle();

    write_reg(rclfp_pkg::REG_MAP_TAER, 8'd1);
    write_reg(rclfp_pkg::REG_IDLE_TIMEOUT, 8'd0);
    hold_req = 1;
    random_phase(25);
    settle();

    write_reg(rclfp_pkg::REG_MAP_TAER, 8'd0);
    write_reg(rclfp_pkg::REG_IDLE_TIMEOUT, 8'd255);
    random_phase(25);
    repeat (12) add_item(1'b1, 8'h00);
    add_item(1'b0, 8'h12);
    settle();

    write_reg(rclfp_pkg::REG_MAP_TAER, 8'd1);
    write_reg(rclfp_pkg::REG_IDLE_TIMEOUT, 8'd1);
    random_phase(30);
    settle();

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
